### rtl/core/hio_pkg.sv
package hio_pkg;

  localparam int VERTICES    = 64;
  localparam int EDGES       = 256;
  localparam int STACK_DEPTH = 64;

  localparam int VIW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int EAW = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int ECW = $clog2(EDGES + 1);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SSW = $clog2(STACK_DEPTH + 1);

  localparam int CMD_W  = 2;
  localparam int VTX_W  = 6;
  localparam int IDX_W  = 8;
  localparam int MASK_W = 64;
  localparam int CFG_W  = 9;
  localparam int STAT_W = 3;
  localparam int PC_W   = 7;

  localparam int IN_DATA_W  = ((VTX_W + IDX_W + MASK_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VTX_W + 1 + PC_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD,
    CMD_PUSH,
    CMD_POP,
    CMD_FIND
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE,
    STAT_VERTEX,
    STAT_NONE,
    STAT_FULL,
    STAT_EMPTY,
    STAT_EMPTY_CIRC
  } stat_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH_CNT,
    ST_POP_TOP,
    ST_POP_CNT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RESP,
    ST_F_RD,
    ST_F_CHK,
    ST_M_RD,
    ST_M_CHK,
    ST_E_RD,
    ST_E_CHK,
    ST_E_OUT
  } st_e;

endpackage

### rtl/core/hypergraph_independence_oracle_unit.sv
// Load, push and pop each end with a scan of the enabled edges, edge_count capped at
// EDGES: each edge is read from memory and then checked against the chosen set.
// Find circuit reads and checks each enabled edge, scans the stack positions for each
// contained edge, and then walks the stack positions to emit the circuit vertices.
// One request is in work at a time and a stalled result holds the unit. Reset clears
// the stack, the chosen set and edge_count.
module hypergraph_independence_oracle_unit import hio_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // vertex, edge_index, edge_mask, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // circuit_vertex, independent, point_count, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [STAT_W-1:0]     m_axis_tuser,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  st_e                 state_q, state_d;
  logic [SSW-1:0]      size_q, size_d;
  logic [VERTICES-1:0] chosen_q, chosen_d;
  logic [CFG_W-1:0]    edge_count_q;
  logic [VIW-1:0]      vtx_q, vtx_d;
  stat_e               status_q, status_d;
  logic                indep_q, indep_d;
  logic [ECW-1:0]      e_q, e_d;
  logic [SSW-1:0]      j_q, j_d;
  logic [VERTICES-1:0] cur_q, cur_d;
  logic [VERTICES-1:0] best_q, best_d;
  logic [SSW-1:0]      best_min_q, best_min_d;
  logic                found_q, found_d;
  logic [VERTICES-1:0] emitted_q, emitted_d;
  logic                out_valid_q, out_valid_d;
  stat_e               out_status_q, out_status_d;
  logic [VTX_W-1:0]    out_vtx_q, out_vtx_d;
  logic                out_last_q, out_last_d;

  logic                e_we;
  logic [EAW-1:0]      e_waddr, e_raddr;
  logic [VERTICES-1:0] e_wdata, e_rdata;
  logic                s_we;
  logic [SAW-1:0]      s_waddr, s_raddr;
  logic [VIW-1:0]      s_wdata, s_rdata;
  logic                c_we;
  logic [VIW-1:0]      c_waddr, c_raddr;
  logic [SSW-1:0]      c_wdata, c_rdata;

  logic                accept;
  cmd_e                in_cmd;
  logic [VTX_W-1:0]    in_vtx;
  logic [IDX_W-1:0]    in_idx;
  logic [MASK_W-1:0]   in_mask;
  logic                vtx_ok, idx_ok, full;
  logic [ECW-1:0]      n_act;
  logic                more_edges, contained, ezero, hit, fresh, last_emit;
  logic [VERTICES-1:0] vbit;
  logic [SSW-1:0]      cnt_now;

  hio_ram #(.WIDTH(VERTICES), .DEPTH(EDGES)) u_edge_ram (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  hio_ram #(.WIDTH(VIW), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  hio_ram #(.WIDTH(SSW), .DEPTH(VERTICES)) u_count_ram (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_cmd        = cmd_e'(s_axis_tuser);
  assign in_vtx        = s_axis_tdata[VTX_W-1:0];
  assign in_idx        = s_axis_tdata[VTX_W +: IDX_W];
  assign in_mask       = s_axis_tdata[VTX_W + IDX_W +: MASK_W];
  assign vtx_ok        = int'(in_vtx) < VERTICES;
  assign idx_ok        = int'(in_idx) < EDGES;
  assign full          = int'(size_q) >= STACK_DEPTH;
  assign n_act         = (32'(edge_count_q) > 32'(EDGES)) ? ECW'(EDGES) : ECW'(edge_count_q);
  assign more_edges    = e_q < n_act;
  assign contained     = (e_rdata & ~chosen_q) == '0;
  assign ezero         = e_rdata == '0;
  assign hit           = cur_q[s_rdata];
  assign vbit          = VERTICES'(1) << s_rdata;
  assign fresh         = best_q[s_rdata] && !emitted_q[s_rdata];
  assign last_emit     = (best_q & ~emitted_q & ~vbit) == '0;
  // A vertex that is not chosen has a count of zero, whatever the memory holds.
  assign cnt_now       = chosen_q[vtx_q] ? c_rdata : '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_LOAD: state_d = ST_SCAN_RD;
            CMD_PUSH: state_d = (vtx_ok && !full) ? ST_PUSH_CNT : ST_SCAN_RD;
            CMD_POP:  state_d = (size_q != '0) ? ST_POP_TOP : ST_SCAN_RD;
            CMD_FIND: state_d = ST_F_RD;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_PUSH_CNT: state_d = ST_SCAN_RD;
      ST_POP_TOP:  state_d = ST_POP_CNT;
      ST_POP_CNT:  state_d = ST_SCAN_RD;
      ST_SCAN_RD:  state_d = more_edges ? ST_SCAN_CHK : ST_RESP;
      ST_SCAN_CHK: state_d = ST_SCAN_RD;
      ST_RESP:     state_d = m_axis_tready ? ST_IDLE : ST_RESP;
      ST_F_RD: begin
        if (more_edges) begin
          state_d = ST_F_CHK;
        end else begin
          state_d = found_q ? ST_E_RD : ST_RESP;
        end
      end
      ST_F_CHK: begin
        if (contained) begin
          state_d = ezero ? ST_RESP : ST_M_RD;
        end else begin
          state_d = ST_F_RD;
        end
      end
      ST_M_RD:  state_d = ST_M_CHK;
      ST_M_CHK: state_d = (hit || (j_q + 1'b1) >= size_q) ? ST_F_RD : ST_M_RD;
      ST_E_RD:  state_d = (j_q < size_q) ? ST_E_CHK : ST_IDLE;
      ST_E_CHK: state_d = fresh ? ST_E_OUT : ST_E_RD;
      ST_E_OUT: begin
        if (m_axis_tready) begin
          state_d = out_last_q ? ST_IDLE : ST_E_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    size_d       = size_q;
    chosen_d     = chosen_q;
    vtx_d        = vtx_q;
    status_d     = status_q;
    indep_d      = indep_q;
    e_d          = e_q;
    j_d          = j_q;
    cur_d        = cur_q;
    best_d       = best_q;
    best_min_d   = best_min_q;
    found_d      = found_q;
    emitted_d    = emitted_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_vtx_d    = out_vtx_q;
    out_last_d   = out_last_q;
    e_we         = 1'b0;
    e_waddr      = EAW'(in_idx);
    e_wdata      = in_mask[VERTICES-1:0];
    e_raddr      = e_q[EAW-1:0];
    s_we         = 1'b0;
    s_waddr      = size_q[SAW-1:0];
    s_wdata      = in_vtx[VIW-1:0];
    s_raddr      = j_q[SAW-1:0];
    c_we         = 1'b0;
    c_waddr      = vtx_q;
    c_wdata      = cnt_now;
    c_raddr      = in_vtx[VIW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          vtx_d    = in_vtx[VIW-1:0];
          status_d = STAT_DONE;
          e_d      = '0;
          indep_d  = 1'b1;
          found_d  = 1'b0;
          case (in_cmd)
            CMD_LOAD: e_we = idx_ok;
            CMD_PUSH: begin
              if (vtx_ok) begin
                if (full) begin
                  status_d = STAT_FULL;
                end else begin
                  s_we = 1'b1;
                end
              end
            end
            CMD_POP: begin
              if (size_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                s_raddr = SAW'(size_q - 1'b1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_PUSH_CNT: begin
        c_we             = 1'b1;
        c_wdata          = cnt_now + 1'b1;
        chosen_d[vtx_q]  = 1'b1;
        size_d           = size_q + 1'b1;
      end
      ST_POP_TOP: begin
        vtx_d   = s_rdata;
        c_raddr = s_rdata;
        size_d  = size_q - 1'b1;
      end
      ST_POP_CNT: begin
        if (cnt_now != '0) begin
          c_we    = 1'b1;
          c_wdata = cnt_now - 1'b1;
          if (cnt_now == SSW'(1)) begin
            chosen_d[vtx_q] = 1'b0;
          end
        end
      end
      ST_SCAN_RD: begin
        if (!more_edges) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_vtx_d    = '0;
          out_last_d   = 1'b1;
        end
      end
      ST_SCAN_CHK: begin
        if (contained) begin
          indep_d = 1'b0;
        end
        e_d = e_q + 1'b1;
      end
      ST_RESP: begin
        if (m_axis_tready) begin
          out_valid_d = 1'b0;
        end
      end
      ST_F_RD: begin
        if (!more_edges) begin
          if (found_q) begin
            j_d       = '0;
            emitted_d = '0;
            indep_d   = 1'b0;
          end else begin
            out_valid_d  = 1'b1;
            out_status_d = STAT_NONE;
            out_vtx_d    = '0;
            out_last_d   = 1'b1;
          end
        end
      end
      ST_F_CHK: begin
        if (contained) begin
          if (ezero) begin
            // The zero edge always wins, so the search stops here.
            indep_d      = 1'b0;
            out_valid_d  = 1'b1;
            out_status_d = STAT_EMPTY_CIRC;
            out_vtx_d    = '0;
            out_last_d   = 1'b1;
          end else begin
            cur_d = e_rdata;
            j_d   = '0;
          end
        end else begin
          e_d = e_q + 1'b1;
        end
      end
      ST_M_CHK: begin
        // The first stack position that hits the edge is its earliest position.
        if (hit) begin
          if (!found_q || j_q > best_min_q) begin
            best_d     = cur_q;
            best_min_d = j_q;
          end
          found_d = 1'b1;
          e_d     = e_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
          if ((j_q + 1'b1) >= size_q) begin
            e_d = e_q + 1'b1;
          end
        end
      end
      ST_E_CHK: begin
        if (fresh) begin
          out_valid_d  = 1'b1;
          out_status_d = STAT_VERTEX;
          out_vtx_d    = VTX_W'(s_rdata);
          out_last_d   = last_emit;
          emitted_d    = emitted_q | vbit;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_E_OUT: begin
        if (m_axis_tready) begin
          out_valid_d = 1'b0;
          j_d         = j_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      size_q       <= '0;
      chosen_q     <= '0;
      out_valid_q  <= 1'b0;
      edge_count_q <= '0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      chosen_q    <= chosen_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        edge_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vtx_q        <= vtx_d;
    status_q     <= status_d;
    indep_q      <= indep_d;
    e_q          <= e_d;
    j_q          <= j_d;
    cur_q        <= cur_d;
    best_q       <= best_d;
    best_min_q   <= best_min_d;
    found_q      <= found_d;
    emitted_q    <= emitted_d;
    out_status_q <= out_status_d;
    out_vtx_q    <= out_vtx_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = OUT_DATA_W'({PC_W'(size_q), indep_q, out_vtx_q});

endmodule

### rtl/core/hio_ram.sv
module hio_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/core/hio_chk.sv
module hio_chk import hio_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [CMD_W-1:0]      s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [STAT_W-1:0]     m_axis_tuser,
  input logic                  m_axis_tlast,
  input logic                  cfg_we_i,
  input logic [CFG_W-1:0]      cfg_wdata_i
);

  // A new request is never taken while a result waits.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("request taken while a result is pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A circuit vertex means a contained edge exists.
  a_circ_dep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_VERTEX |-> !m_axis_tdata[VTX_W])
    else $error("circuit vertex reported with independent set");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != STAT_VERTEX |->
      m_axis_tlast && m_axis_tdata[VTX_W-1:0] == '0)
    else $error("single result not last or carries a vertex");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> int'(m_axis_tdata[VTX_W + 1 +: PC_W]) <= STACK_DEPTH)
    else $error("point count above stack depth");

endmodule

bind hypergraph_independence_oracle_unit hio_chk u_hio_chk (.*);

### test/hypergraph_independence_oracle_unit_tb.sv
`timescale 1ns / 100ps

module hypergraph_independence_oracle_unit_tb;
  import hio_pkg::*;

  localparam int LIMIT_CYCLES = 80000000;

  typedef struct {
    stat_e       status;
    logic [5:0]  vtx;
    logic        last;
    logic        indep;
    logic [6:0]  count;
  } oracle_reply_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [CMD_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]     m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we_i;
  logic [CFG_W-1:0]      cfg_wdata_i;

  // Shadow copy of the block state.
  logic [63:0]   sh_edges [EDGES];
  logic [5:0]    sh_stack [STACK_DEPTH];
  int unsigned   sh_depth;
  int unsigned   sh_occur [64];
  int unsigned   sh_edge_count;

  oracle_reply_t replies_due[$];
  int            fail_count;
  int unsigned   cycle_count;
  int            send_idle_pct;
  int            recv_idle_pct;

  hypergraph_independence_oracle_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned enabled_edges();
    return (sh_edge_count < EDGES) ? sh_edge_count : EDGES;
  endfunction

  function automatic logic [63:0] chosen_set();
    logic [63:0] m;
    m = '0;
    for (int v = 0; v < 64; v++) if (sh_occur[v] != 0) m[v] = 1'b1;
    return m;
  endfunction

  function automatic logic set_is_independent();
    logic [63:0] chosen;
    chosen = chosen_set();
    for (int e = 0; e < enabled_edges(); e++)
      if ((sh_edges[e] & ~chosen) == '0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void add_reply(stat_e st, logic [5:0] v, logic lst, logic ind);
    oracle_reply_t r;
    r.status = st;
    r.vtx    = v;
    r.last   = lst;
    r.indep  = ind;
    r.count  = sh_depth[6:0];
    replies_due = {replies_due, r};
  endfunction

  // Picks the contained edge whose earliest stack position is latest and
  // queues its vertices in stack order.
  function automatic void predict_circuit();
    logic        ind;
    logic [63:0] chosen, m, best;
    int unsigned first_pos [64];
    int unsigned mn, best_min;
    bit          found, empty;
    int          last_j;
    ind = set_is_independent();
    chosen = chosen_set();
    found = 0;
    empty = 0;
    best = '0;
    best_min = 0;
    for (int v = 0; v < 64; v++) first_pos[v] = 32'hFFFF_FFFF;
    for (int j = int'(sh_depth) - 1; j >= 0; j--) first_pos[sh_stack[j]] = j;
    for (int e = 0; e < enabled_edges(); e++) begin
      m = sh_edges[e];
      if ((m & ~chosen) != '0) continue;
      if (m == '0) begin
        empty = 1;
        break;
      end
      mn = 32'hFFFF_FFFF;
      for (int v = 0; v < 64; v++) if (m[v] && first_pos[v] < mn) mn = first_pos[v];
      if (!found || mn > best_min) begin
        found = 1;
        best_min = mn;
        best = m;
      end
    end
    if (empty) add_reply(STAT_EMPTY_CIRC, 6'd0, 1'b1, ind);
    else if (!found) add_reply(STAT_NONE, 6'd0, 1'b1, ind);
    else begin
      last_j = -1;
      for (int j = 0; j < int'(sh_depth); j++)
        if (best[sh_stack[j]] && first_pos[sh_stack[j]] == j) last_j = j;
      for (int j = 0; j < int'(sh_depth); j++)
        if (best[sh_stack[j]] && first_pos[sh_stack[j]] == j)
          add_reply(STAT_VERTEX, sh_stack[j], j == last_j, ind);
    end
  endfunction

  function automatic void predict_request(cmd_e cmd, logic [5:0] vtx, logic [7:0] idx,
                                          logic [63:0] mask);
    stat_e st;
    st = STAT_DONE;
    case (cmd)
      CMD_LOAD: sh_edges[idx] = mask;
      CMD_PUSH: begin
        if (sh_depth >= STACK_DEPTH) st = STAT_FULL;
        else begin
          sh_stack[sh_depth] = vtx;
          sh_depth++;
          sh_occur[vtx]++;
        end
      end
      CMD_POP: begin
        if (sh_depth == 0) st = STAT_EMPTY;
        else begin
          sh_depth--;
          if (sh_occur[sh_stack[sh_depth]] != 0) sh_occur[sh_stack[sh_depth]]--;
        end
      end
      default: begin
        predict_circuit();
        return;
      end
    endcase
    add_reply(st, 6'd0, 1'b1, set_is_independent());
  endfunction

  task automatic send_request(cmd_e cmd, logic [5:0] vtx, logic [7:0] idx, logic [63:0] mask);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, mask, idx, vtx};
    predict_request(cmd, vtx, idx, mask);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Waits for every reply, then for the scan of the last request to finish.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (2 * enabled_edges() + 40) @(posedge clk_i);
  endtask

  task automatic write_edge_count(logic [8:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sh_edge_count = value;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] small_edge();
    logic [63:0] m;
    m = '0;
    repeat ($urandom_range(3, 1)) m[$urandom_range(15)] = 1'b1;
    return m;
  endfunction

  function automatic logic [63:0] wide_edge();
    return {$urandom(), $urandom()};
  endfunction

  // Every slot is written once so that no enabled slot is ever unwritten.
  task automatic test_fill_table();
    for (int e = 0; e < EDGES; e++)
      send_request(CMD_LOAD, 6'($urandom()), 8'(e), wide_edge() | 64'h1);
  endtask

  task automatic test_directed();
    write_edge_count(9'd4);
    send_request(CMD_LOAD, 6'd63, 8'd0, 64'h6);
    send_request(CMD_LOAD, 6'd0, 8'd1, 64'h8);
    send_request(CMD_LOAD, 6'd0, 8'd2, '1);
    send_request(CMD_LOAD, 6'd0, 8'd3, 64'h8000_0000_0000_0000);
    send_request(CMD_POP, 6'd0, 8'd0, '0);
    send_request(CMD_FIND, 6'd0, 8'd0, '0);
    send_request(CMD_PUSH, 6'd3, 8'd0, '0);
    send_request(CMD_PUSH, 6'd1, 8'd0, '0);
    send_request(CMD_PUSH, 6'd3, 8'd0, '0);
    send_request(CMD_PUSH, 6'd2, 8'd0, '0);
    send_request(CMD_FIND, 6'd0, 8'd0, '0);
    send_request(CMD_PUSH, 6'd63, 8'd0, '0);
    send_request(CMD_FIND, 6'd0, 8'd0, '0);
    // A zero edge is always contained and wins the search.
    send_request(CMD_LOAD, 6'd0, 8'd1, '0);
    send_request(CMD_FIND, 6'd0, 8'd0, '0);
    send_request(CMD_LOAD, 6'd0, 8'd1, 64'h8);
    repeat (5) send_request(CMD_POP, 6'd0, 8'd0, '0);
    write_edge_count(9'd511);
    send_request(CMD_FIND, 6'd0, 8'd0, '0);
    write_edge_count(9'd0);
  endtask

  task automatic test_stack_limits();
    write_edge_count(9'd0);
    for (int i = 0; i < STACK_DEPTH + 1; i++)
      send_request(CMD_PUSH, (i == 0) ? 6'd0 : (i == 1) ? 6'd63 : 6'($urandom()), 8'd0, '0);
    write_edge_count(9'd256);
    send_request(CMD_FIND, 6'd0, 8'd0, '0);
    write_edge_count(9'd0);
    for (int i = 0; i < STACK_DEPTH + 1; i++) send_request(CMD_POP, 6'd0, 8'd0, '0);
  endtask

  task automatic test_random(int snd_pct, int rcv_pct, int items);
    int sel, slots;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int i = 0; i < items; i++) begin
      if (i % 6 == 0) begin
        sel = $urandom_range(99);
        write_edge_count(sel < 70 ? 9'($urandom_range(16, 1)) : sel < 85 ? 9'd256 : 9'd511);
      end
      slots = (enabled_edges() < 16) ? enabled_edges() : 16;
      sel = $urandom_range(99);
      if (sh_depth > 20 && sel < 50) sel = 40;
      if (sel < 35)
        send_request(CMD_PUSH, ($urandom_range(9) == 0) ? 6'($urandom()) :
                     6'($urandom_range(15)), 8'd0, '0);
      else if (sel < 58) send_request(CMD_POP, 6'd0, 8'd0, '0);
      else if (sel < 80) send_request(CMD_FIND, 6'($urandom()), 8'($urandom()), wide_edge());
      else begin
        sel = $urandom_range(99);
        send_request(CMD_LOAD, 6'($urandom()), 8'($urandom_range(slots - 1)),
                     sel < 4 ? 64'h0 : sel < 12 ? wide_edge() : small_edge());
      end
    end
    drain();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_LOAD;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    fail_count    = 0;
    send_idle_pct = 33;
    recv_idle_pct = 73;
    sh_depth      = 0;
    sh_edge_count = 0;
    for (int v = 0; v < 64; v++) sh_occur[v] = 0;
    for (int e = 0; e < EDGES; e++) sh_edges[e] = '0;
    for (int j = 0; j < STACK_DEPTH; j++) sh_stack[j] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_table();
    test_directed();
    test_stack_limits();
    test_random(33, 73, 17);
    test_random(73, 33, 17);
    test_random(0, 0, 17);
    drain();
    if (fail_count == 0 && replies_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    oracle_reply_t r;
    if (m_axis_tvalid && m_axis_tready) begin
      if (replies_due.size() == 0) begin
        $error("unexpected reply status %0d", m_axis_tuser);
        fail_count++;
      end else begin
        r = replies_due.pop_front();
        if (m_axis_tuser !== r.status) begin
          $error("status: expected %0d, actual %0d", r.status, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[5:0] !== r.vtx) begin
          $error("circuit_vertex: expected %0d, actual %0d", r.vtx, m_axis_tdata[5:0]);
          fail_count++;
        end
        if (m_axis_tlast !== r.last) begin
          $error("last: expected %0d, actual %0d", r.last, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tdata[6] !== r.indep) begin
          $error("independent: expected %0d, actual %0d", r.indep, m_axis_tdata[6]);
          fail_count++;
        end
        if (m_axis_tdata[13:7] !== r.count) begin
          $error("point_count: expected %0d, actual %0d", r.count, m_axis_tdata[13:7]);
          fail_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
